// ===== rtl/core/swr_pkg.sv =====
// Shared types and constants of the sliding window rank block.
// Used by swr_cell, swr_rank and sliding_window_rank; depends on nothing.
package swr_pkg;

   localparam int WINDOW_MAX  = 128;
   localparam int SAMPLE_BITS = 32;

   localparam int LEN_W      = 8;
   localparam int TOL_W      = 16;
   localparam int PTR_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int EXT_W      = (LEN_W > CNT_W) ? LEN_W : CNT_W;
   localparam int RANK_W     = 13;
   localparam int PROD_W     = 2 * CNT_W;

   localparam int GRP        = 8;
   localparam int NGRP       = (WINDOW_MAX + GRP - 1) / GRP;
   localparam int QUAD       = 4;
   localparam int NQUAD      = (NGRP + QUAD - 1) / QUAD;
   localparam int GCNT_W     = $clog2(GRP + 1);
   localparam int QCNT_W     = $clog2(QUAD * GRP + 1);

   localparam int REQ_W      = 32;
   localparam int RSP_W      = 32;
   localparam int RSP_PAD    = RSP_W - (RANK_W + 2 * CNT_W + 2);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEN_W-1:0]       LEN_RESET   = LEN_W'(128);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_SIGN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WINDOW_LEN = 1'b0,
      REG_TIE_TOL    = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_EVICT,
      CELL_INSERT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [SAMPLE_BITS-1:0] key;
      logic [TOL_W-1:0]       tol;
   } cell_cmd_type;

   typedef struct packed {
      logic tie;
      logic above;
   } cell_flag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_INSERT,
      ST_TALLY,
      ST_RANK
   } state_type;

endpackage

// ===== rtl/core/swr_cell.sv =====
// One cell of the sorted chain: holds one window entry and its valid bit.
// Depends on swr_pkg.
module swr_cell import swr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_cmd_type           cmd,
   input  logic [SAMPLE_BITS-1:0] prev_value,
   input  logic                   prev_valid,
   input  logic                   prev_lt,
   input  logic [SAMPLE_BITS-1:0] next_value,
   input  logic                   next_valid,
   output logic [SAMPLE_BITS-1:0] value,
   output logic                   valid,
   output logic                   lt,
   output cell_flag_type          flag
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   greater;
   logic                   tie;

   assign value = value_ff;
   assign valid = valid_ff;

   // An empty cell sorts below every sample, so the insert point lands after the
   // last held entry.
   assign lt = !valid_ff || (value_ff < cmd.key);

   assign greater = value_ff > cmd.key;
   assign diff    = greater ? (value_ff - cmd.key) : (cmd.key - value_ff);
   assign tie     = valid_ff &&
                    ({{TOL_W{1'b0}}, diff} <= {{SAMPLE_BITS{1'b0}}, cmd.tol});
   assign flag.tie   = tie;
   assign flag.above = valid_ff && greater && !tie;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (cmd.op)
         CELL_EVICT: begin
            // Entries from the first one equal to the evicted sample onward move up.
            if (!valid_ff || (value_ff <= cmd.key)) begin
               value_in = next_value;
               valid_in = next_valid;
            end
         end
         CELL_INSERT: begin
            if (lt && prev_lt) begin
               value_in = prev_value;
               valid_in = prev_valid;
            end else if (lt) begin
               value_in = cmd.key;
               valid_in = 1'b1;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/core/swr_rank.sv =====
// Registered tally of the cell flags into tie count and rank sum.
// Depends on swr_pkg.
module swr_rank import swr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cell_flag_type       flags [WINDOW_MAX],
   output logic                done,
   output logic [RANK_W-1:0]   rank_sum,
   output logic [CNT_W-1:0]    tie_count
);

   logic [GCNT_W-1:0] grp_tie_ff [NGRP];
   logic [GCNT_W-1:0] grp_above_ff [NGRP];
   logic [GCNT_W-1:0] grp_tie_in [NGRP];
   logic [GCNT_W-1:0] grp_above_in [NGRP];
   logic [QCNT_W-1:0] quad_tie_ff [NQUAD];
   logic [QCNT_W-1:0] quad_above_ff [NQUAD];
   logic [QCNT_W-1:0] quad_tie_in [NQUAD];
   logic [QCNT_W-1:0] quad_above_in [NQUAD];
   logic [CNT_W-1:0]  tie_total_ff, tie_total_in;
   logic [CNT_W-1:0]  above_total_ff, above_total_in;
   logic [RANK_W-1:0] rank_sum_ff, rank_sum_in;
   logic [CNT_W-1:0]  tie_count_ff;
   logic [PROD_W-1:0] prod_first;
   logic [PROD_W-1:0] prod_pairs;
   logic              s1_ff, s2_ff, s3_ff, done_ff;

   // Groups of eight cells each.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_tie_in[g]   = '0;
         grp_above_in[g] = '0;
         for (int b = 0; b < GRP; b++) begin
            if (g * GRP + b < WINDOW_MAX) begin
               grp_tie_in[g]   = grp_tie_in[g] + GCNT_W'(flags[g * GRP + b].tie);
               grp_above_in[g] = grp_above_in[g] + GCNT_W'(flags[g * GRP + b].above);
            end
         end
      end
   end

   always_comb begin
      for (int q = 0; q < NQUAD; q++) begin
         quad_tie_in[q]   = '0;
         quad_above_in[q] = '0;
         for (int k = 0; k < QUAD; k++) begin
            if (q * QUAD + k < NGRP) begin
               quad_tie_in[q]   = quad_tie_in[q] + QCNT_W'(grp_tie_ff[q * QUAD + k]);
               quad_above_in[q] = quad_above_in[q] + QCNT_W'(grp_above_ff[q * QUAD + k]);
            end
         end
      end
   end

   always_comb begin
      tie_total_in   = '0;
      above_total_in = '0;
      for (int q = 0; q < NQUAD; q++) begin
         tie_total_in   = tie_total_in + CNT_W'(quad_tie_ff[q]);
         above_total_in = above_total_in + CNT_W'(quad_above_ff[q]);
      end
   end

   // Tied entries sit in one contiguous run that starts right after the
   // entries above the tolerance band, so the index sum is closed form.
   assign prod_first  = PROD_W'(tie_total_ff) * PROD_W'(above_total_ff);
   assign prod_pairs  = PROD_W'(tie_total_ff) * PROD_W'(tie_total_ff - CNT_W'(1));
   assign rank_sum_in = RANK_W'(prod_first + (prod_pairs >> 1));

   always_ff @(posedge clock) begin
      grp_tie_ff     <= grp_tie_in;
      grp_above_ff   <= grp_above_in;
      quad_tie_ff    <= quad_tie_in;
      quad_above_ff  <= quad_above_in;
      tie_total_ff   <= tie_total_in;
      above_total_ff <= above_total_in;
      if (s3_ff) begin
         rank_sum_ff  <= rank_sum_in;
         tie_count_ff <= tie_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= 1'b0;
         s2_ff   <= 1'b0;
         s3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= start;
         s2_ff   <= s1_ff;
         s3_ff   <= s2_ff;
         done_ff <= start ? 1'b0 : (done_ff || s3_ff);
      end
   end

   assign done      = done_ff;
   assign rank_sum  = rank_sum_ff;
   assign tie_count = tie_count_ff;

endmodule

// ===== rtl/core/sliding_window_rank.sv =====
// Top level of the sliding window rank block: arrival ring, sorted cell chain,
// sequencer and result register. Depends on swr_pkg, swr_cell and swr_rank.
//
// Each item carries one signed Q16.16 sample. The block keeps the last
// window_len samples (2 to 128; smaller values act as 2, larger as 128) and a
// copy of them sorted from largest to smallest in a chain of 128 cells. For
// every sample it returns one item with the sum of the sorted positions
// (0 = largest) of all held entries within tie_tolerance of the sample, the
// number of those entries, the window fill after the sample, a flag that the
// fill exceeds one, and a flag that the window is full. Software forms the
// quantile as rank_sum / (tie_count * (fill_count - 1)) and uses 0.5 when
// rank_valid is low. For each item, once the window is full, the cell chain
// first removes the oldest sample; it then inserts the new one, and the tie
// tally runs through a three-stage registered adder tree and a registered
// rank product. A result waits in an output register, so the next item is
// accepted while the previous result is still pending; a new result is held
// back only while that register is occupied and not being taken. Writing
// window_len empties the window at once (no clearing pass); writing
// tie_tolerance keeps it. The user must write configuration only while no
// item is in progress; the block itself does not enforce this.
module sliding_window_rank import swr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Sample items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // [31:0] sample
   // Rank items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // [12:0] rank_sum, [20:13] tie_count,
                                              // [28:21] fill_count, [29] rank_valid,
                                              // [30] window_full, [31] zero
   // Register writes.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       win_len_ff, win_len_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] old_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff;
   logic                   rsp_load;

   logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];

   logic [CNT_W-1:0]       len_eff;
   logic [CNT_W-1:0]       fill_cur;
   logic [PTR_W-1:0]       ptr_cur;
   logic [CNT_W-1:0]       ptr_next;
   logic                   full_now;
   logic                   req_fire;
   logic [SAMPLE_BITS-1:0] sample_in;
   logic                   len_write;
   logic                   rank_start;

   cell_cmd_type           cell_cmd;
   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]  cell_valid;
   logic [WINDOW_MAX-1:0]  cell_lt;
   cell_flag_type          cell_flag [WINDOW_MAX];

   logic                   rank_done;
   logic [RANK_W-1:0]      rank_sum;
   logic [CNT_W-1:0]       tie_count;

   // Window length as used, clamped to the legal range.
   always_comb begin
      if (EXT_W'(win_len_ff) < EXT_W'(2)) begin
         len_eff = CNT_W'(2);
      end else if (EXT_W'(win_len_ff) > EXT_W'(WINDOW_MAX)) begin
         len_eff = CNT_W'(WINDOW_MAX);
      end else begin
         len_eff = CNT_W'(win_len_ff);
      end
   end

   assign fill_cur  = (fill_ff > len_eff) ? len_eff : fill_ff;
   assign ptr_cur   = (CNT_W'(ptr_ff) >= len_eff) ? '0 : ptr_ff;
   assign ptr_next  = CNT_W'(ptr_cur) + CNT_W'(1);
   assign full_now  = (fill_cur == len_eff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   // Offset binary: flipping the sign bit makes unsigned order match signed order.
   assign sample_in = req_tdata[SAMPLE_BITS-1:0] ^ SAMPLE_SIGN;
   assign len_write = csr_we && (csr_reg_type'(csr_index) == REG_WINDOW_LEN);

   // Sequencer and register next values.
   always_comb begin
      state_in     = state_ff;
      win_len_in   = win_len_ff;
      tol_in       = tol_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      rank_start   = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fill_in  = full_now ? fill_cur : (fill_cur + CNT_W'(1));
               ptr_in   = (ptr_next >= len_eff) ? '0 : PTR_W'(ptr_next);
               state_in = full_now ? ST_EVICT : ST_INSERT;
            end
         end
         ST_EVICT: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            state_in = ST_TALLY;
         end
         ST_TALLY: begin
            rank_start = 1'b1;
            state_in   = ST_RANK;
         end
         ST_RANK: begin
            if (rank_done && (!rsp_valid_ff || rsp_tready)) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_WINDOW_LEN: begin
               win_len_in = csr_wdata[LEN_W-1:0];
               fill_in    = '0;
               ptr_in     = '0;
            end
            REG_TIE_TOL: begin
               tol_in = csr_wdata[TOL_W-1:0];
            end
            default: begin
               tol_in = tol_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_len_ff   <= LEN_RESET;
         tol_ff       <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         tol_ff       <= tol_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Arrival ring: the oldest sample is read out as the new one replaces it.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         old_ff        <= ring[ptr_cur];
         ring[ptr_cur] <= sample_in;
         sample_ff     <= sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {{RSP_PAD{1'b0}},
                         (fill_ff == len_eff),
                         (fill_ff > CNT_W'(1)),
                         fill_ff,
                         tie_count,
                         rank_sum};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Command broadcast to every cell.
   always_comb begin
      cell_cmd.tol = tol_ff;
      cell_cmd.key = sample_ff;
      cell_cmd.op  = CELL_HOLD;
      if (state_ff == ST_EVICT) begin
         cell_cmd.op  = CELL_EVICT;
         cell_cmd.key = old_ff;
      end else if (state_ff == ST_INSERT) begin
         cell_cmd.op = CELL_INSERT;
      end else if (len_write) begin
         cell_cmd.op = CELL_CLEAR;
      end
   end

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] prev_value;
      logic                   prev_valid;
      logic                   prev_lt;
      logic [SAMPLE_BITS-1:0] next_value;
      logic                   next_valid;

      if (i == 0) begin : g_first
         assign prev_value = sample_ff;
         assign prev_valid = 1'b0;
         assign prev_lt    = 1'b0;
      end else begin : g_mid
         assign prev_value = cell_value[i - 1];
         assign prev_valid = cell_valid[i - 1];
         assign prev_lt    = cell_lt[i - 1];
      end

      if (i == WINDOW_MAX - 1) begin : g_last
         assign next_value = '0;
         assign next_valid = 1'b0;
      end else begin : g_body
         assign next_value = cell_value[i + 1];
         assign next_valid = cell_valid[i + 1];
      end

      swr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_lt    (prev_lt),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .lt         (cell_lt[i]),
         .flag       (cell_flag[i])
      );
   end

   swr_rank u_rank (
      .clock     (clock),
      .reset     (reset),
      .start     (rank_start),
      .flags     (cell_flag),
      .done      (rank_done),
      .rank_sum  (rank_sum),
      .tie_count (tie_count)
   );

   // The fill never exceeds the window length in use.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("fill count beyond window length");

   // The ring pointer stays inside the window.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(ptr_ff) < len_eff)
      else $error("ring pointer outside window");

   // After insertion the chain holds exactly as many entries as the fill count.
   a_chain_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TALLY) |-> ($countones(cell_valid) == int'(fill_ff)))
      else $error("sorted chain out of step with fill count");

   // An accepted item goes straight to the chain update.
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EVICT || state_ff == ST_INSERT))
      else $error("accepted item did not start a chain update");

   // The new sample always ties with itself.
   a_tie_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RANK_W +: CNT_W] != '0))
      else $error("result with zero tie count");

endmodule
